>>> rtl/mfrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfrs_pkg;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_ROUND = 1'b1;

  localparam logic [15:0] SLICE_RESET = 16'd4;

  typedef enum logic [2:0] {
    OC_FINISHED = 3'd0,
    OC_DEMOTED  = 3'd1,
    OC_DROPPED  = 3'd2,
    OC_ZERO     = 3'd3,
    OC_ADMITTED = 3'd4,
    OC_REJECTED = 3'd5,
    OC_IDLE     = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
  } task_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  task_id;
    logic [15:0] burst;
    logic [1:0]  level;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/mfrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mfrs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          mode,
  input  wire logic [7:0]    task_id,
  input  wire logic [15:0]   burst,
  input  wire logic [1:0]    level,
  output logic               cmd_valid,
  output mfrs_pkg::cmd_t     cmd,
  input  wire logic          cmd_pop
);
  import mfrs_pkg::*;

  // two-entry command queue between accept side and sequencer
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign busy      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= '{mode: mode, task_id: task_id, burst: burst, level: level};
        wr_ptr    <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mfrs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mfrs_back #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          quantum_we,
  input  wire logic [15:0]   quantum,
  input  wire logic          cmd_valid,
  input  wire mfrs_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               strobe,
  output logic [7:0]         served_id,
  output logic [1:0]         served_level,
  output logic [2:0]         outcome,
  output logic [15:0]        remaining,
  output logic               last
);
  import mfrs_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_VISIT = 3'b010,
    S_SERVE = 3'b100
  } state_t;

  state_t        state;
  logic [15:0]   slice_len;
  logic [LW-1:0] cur;
  logic [PW-1:0] head [LEVELS];
  logic [PW-1:0] tail [LEVELS];
  logic [CW-1:0] cnt  [LEVELS];

  task_t         mem [DEPTH];
  task_t         rd_data;
  logic          mem_we;
  logic [AW-1:0] waddr;
  task_t         wdata;
  logic          mem_re;
  logic [AW-1:0] raddr;

  logic          adm_ok;
  logic [LW-1:0] adm_lvl;
  logic          all_empty;
  logic [LW-1:0] lower;
  logic          over;
  logic [15:0]   rem;
  logic          moved;
  logic          below_busy;
  logic          serve_last;
  outcome_t      serve_oc;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return AW'(AW'(l) * AW'(QUEUE_DEPTH) + AW'(p));
  endfunction

  assign adm_lvl = LW'(cmd.level);
  assign adm_ok  = (32'(cmd.level) < LEVELS) && (cnt[adm_lvl] < CW'(QUEUE_DEPTH));
  assign lower   = cur - LW'(1);
  assign over    = rd_data.burst > slice_len;
  assign rem     = rd_data.burst - slice_len;
  assign moved   = over && (cur != '0) && (cnt[lower] < CW'(QUEUE_DEPTH));
  assign serve_last = !(moved || below_busy);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_comb begin
    all_empty  = 1'b1;
    below_busy = 1'b0;
    for (int j = 0; j < LEVELS; j++) begin
      if (cnt[j] != '0) begin
        all_empty = 1'b0;
        if (LW'(j) < cur) begin
          below_busy = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (!over) begin
      serve_oc = (rd_data.burst != 16'd0) ? OC_FINISHED : OC_ZERO;
    end else if (moved) begin
      serve_oc = OC_DEMOTED;
    end else begin
      serve_oc = OC_DROPPED;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = addr_of(lower, tail[lower]);
    wdata  = '{id: rd_data.id, burst: rem};
    if (state == S_IDLE && cmd_valid && cmd.mode == MODE_ADMIT && adm_ok) begin
      mem_we = 1'b1;
      waddr  = addr_of(adm_lvl, tail[adm_lvl]);
      wdata  = '{id: cmd.task_id, burst: cmd.burst};
    end else if (state == S_SERVE && moved) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state == S_VISIT) && (cnt[cur] != '0);
  assign raddr  = addr_of(cur, head[cur]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      slice_len <= SLICE_RESET;
      cur       <= '0;
      for (int j = 0; j < LEVELS; j++) begin
        head[j] <= '0;
        tail[j] <= '0;
        cnt[j]  <= '0;
      end
    end else begin
      strobe <= 1'b0;
      if (quantum_we) begin
        slice_len <= quantum;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.mode == MODE_ADMIT) begin
              strobe       <= 1'b1;
              served_id    <= cmd.task_id;
              served_level <= cmd.level;
              outcome      <= adm_ok ? OC_ADMITTED : OC_REJECTED;
              remaining    <= cmd.burst;
              last         <= 1'b1;
              if (adm_ok) begin
                tail[adm_lvl] <= ptr_inc(tail[adm_lvl]);
                cnt[adm_lvl]  <= cnt[adm_lvl] + CW'(1);
              end
            end else if (all_empty) begin
              strobe       <= 1'b1;
              served_id    <= 8'd0;
              served_level <= 2'd0;
              outcome      <= OC_IDLE;
              remaining    <= 16'd0;
              last         <= 1'b1;
            end else begin
              cur   <= LW'(LEVELS - 1);
              state <= S_VISIT;
            end
          end
        end
        S_VISIT: begin
          if (cnt[cur] != '0) begin
            head[cur] <= ptr_inc(head[cur]);
            cnt[cur]  <= cnt[cur] - CW'(1);
            state     <= S_SERVE;
          end else if (cur == '0) begin
            state <= S_IDLE;
          end else begin
            cur <= lower;
          end
        end
        S_SERVE: begin
          strobe       <= 1'b1;
          served_id    <= rd_data.id;
          served_level <= 2'(cur);
          outcome      <= serve_oc;
          remaining    <= over ? rem : 16'd0;
          last         <= serve_last;
          if (moved) begin
            tail[lower] <= ptr_inc(tail[lower]);
            cnt[lower]  <= cnt[lower] + CW'(1);
          end
          if (serve_last) begin
            state <= S_IDLE;
          end else begin
            cur   <= lower;
            state <= S_VISIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/multilevel_feedback_round_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Multilevel feedback round scheduler: one task FIFO per priority level.
// Commands enter on start when busy is low (mode, task_id, burst, level).
// mode 0 admits a task into a level, mode 1 runs one round that visits the
// levels from highest to lowest and serves each non-empty head once.
// Results leave on served_id/served_level/outcome/remaining/last, valid for
// exactly one cycle while strobe is high; last marks the final result of a
// command. The receiver cannot stall, so every strobe is a transaction.
// A two-entry command queue sits in front of the sequencer; busy is high
// only while that queue is full.
// An admit result is registered from the queued command, and admits can
// follow one per cycle while no round is running. A round is dispatched
// from idle, then passes each empty level and serves each non-empty one
// (one task store read, then compute and write-back); an all-empty round
// gives one idle result. A round gives at most LEVELS results.
// quantum is loaded on quantum_we and should change only when idle.
// Synchronous reset empties all levels, drops queued commands and sets
// the time slice to 4; the task store itself is not cleared.
module multilevel_feedback_round_scheduler #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [7:0]  task_id,
  input  wire logic [15:0] burst,
  input  wire logic [1:0]  level,
  input  wire logic        quantum_we,
  input  wire logic [15:0] quantum,
  output logic             strobe,
  output logic [7:0]       served_id,
  output logic [1:0]       served_level,
  output logic [2:0]       outcome,
  output logic [15:0]      remaining,
  output logic             last
);
  import mfrs_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  mfrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .task_id   (task_id),
    .burst     (burst),
    .level     (level),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mfrs_back #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .quantum_we    (quantum_we),
    .quantum       (quantum),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .strobe        (strobe),
    .served_id     (served_id),
    .served_level  (served_level),
    .outcome       (outcome),
    .remaining     (remaining),
    .last          (last)
  );

endmodule

`default_nettype wire

>>> rtl/mfrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        strobe,
  input wire logic [7:0]  served_id,
  input wire logic [2:0]  outcome,
  input wire logic [15:0] remaining,
  input wire logic        last
);
  import mfrs_pkg::*;

  // nothing comes out in the cycle after a reset edge
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe right after reset");

  // an idle round is a lone, empty result
  a_idle_shape: assert property (@(posedge clk) disable iff (rst)
    (strobe && outcome == OC_IDLE) |-> (last && served_id == 8'd0 && remaining == 16'd0))
    else $error("malformed idle result");

  // admit results always close their command
  a_admit_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (outcome == OC_ADMITTED || outcome == OC_REJECTED)) |-> last)
    else $error("admit result without last");

  // finished and zero-burst tasks leave nothing behind
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (strobe && (outcome == OC_FINISHED || outcome == OC_ZERO)) |-> remaining == 16'd0)
    else $error("finished task with burst left");

  // busy only rises after an accepted transaction
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    ($past(!busy) && $past(!start)) |-> !busy)
    else $error("busy rose without a transaction");

endmodule

bind multilevel_feedback_round_scheduler mfrs_checker u_mfrs_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mfrs_pkg::*;

  localparam int NUM_LEVELS  = 4;
  localparam int QDEPTH      = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 85;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    logic        mode;
    logic [7:0]  id;
    logic [15:0] burst;
    logic [1:0]  lvl;
    logic        typed;
    outcome_t    e_oc;
    logic [15:0] e_rem;
  } stim_row_t;

  typedef struct {
    logic [7:0]  id;
    logic [1:0]  lvl;
    outcome_t    oc;
    logic [15:0] rem;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = MODE_ADMIT;
  logic [7:0]  task_id = 8'd0;
  logic [15:0] burst = 16'd0;
  logic [1:0]  level = 2'd0;
  logic        quantum_we = 1'b0;
  logic [15:0] quantum = SLICE_RESET;
  logic        strobe;
  logic [7:0]  served_id;
  logic [1:0]  served_level;
  logic [2:0]  outcome;
  logic [15:0] remaining;
  logic        last;

  multilevel_feedback_round_scheduler #(
    .LEVELS(NUM_LEVELS),
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .task_id(task_id),
    .burst(burst),
    .level(level),
    .quantum_we(quantum_we),
    .quantum(quantum),
    .strobe(strobe),
    .served_id(served_id),
    .served_level(served_level),
    .outcome(outcome),
    .remaining(remaining),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scheduler state as the block should hold it
  logic [7:0]  store_id    [NUM_LEVELS][QDEPTH];
  logic [15:0] store_burst [NUM_LEVELS][QDEPTH];
  int unsigned lv_head  [NUM_LEVELS];
  int unsigned lv_tail  [NUM_LEVELS];
  int unsigned lv_count [NUM_LEVELS];
  logic [15:0] slice_now = SLICE_RESET;

  result_t   pending_results[$];
  result_t   next_result;
  stim_row_t directed_rows [9];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        run_left = 0;
  int        admit_pct [6] = '{70, 85, 50, 75, 40, 65};
  logic [15:0] slice_plan [6];

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit enqueue_task(input int lv, input logic [7:0] id,
                                      input logic [15:0] b);
    if (lv_count[lv] >= QDEPTH)
      return 1'b0;
    store_id[lv][lv_tail[lv]] = id;
    store_burst[lv][lv_tail[lv]] = b;
    lv_tail[lv] = (lv_tail[lv] + 1) % QDEPTH;
    lv_count[lv]++;
    return 1'b1;
  endfunction

  // expected results of one command, appended to pending_results
  task automatic predict_schedule(input stim_row_t row);
    result_t     r;
    result_t     held;
    bit          have_held;
    bit          moved;
    logic [7:0]  id;
    logic [15:0] b;
    logic [15:0] rest;
    if (row.mode == MODE_ADMIT) begin
      r.id = row.id;
      r.lvl = row.lvl;
      r.rem = row.burst;
      r.last = 1'b1;
      r.oc = enqueue_task(int'(row.lvl), row.id, row.burst) ? OC_ADMITTED : OC_REJECTED;
      pending_results.push_back(r);
    end else begin
      have_held = 1'b0;
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
        if (lv_count[lv] == 0)
          continue;
        id = store_id[lv][lv_head[lv]];
        b = store_burst[lv][lv_head[lv]];
        lv_head[lv] = (lv_head[lv] + 1) % QDEPTH;
        lv_count[lv]--;
        r.id = id;
        r.lvl = 2'(lv);
        r.last = 1'b0;
        if (b > slice_now) begin
          rest = b - slice_now;
          // the demoted task lands in a level not yet visited this round
          moved = (lv > 0) && enqueue_task(lv - 1, id, rest);
          r.oc = moved ? OC_DEMOTED : OC_DROPPED;
          r.rem = rest;
        end else if (b != 16'd0) begin
          r.oc = OC_FINISHED;
          r.rem = 16'd0;
        end else begin
          r.oc = OC_ZERO;
          r.rem = 16'd0;
        end
        if (have_held)
          pending_results.push_back(held);
        held = r;
        have_held = 1'b1;
      end
      if (!have_held) begin
        held.id = 8'd0;
        held.lvl = 2'd0;
        held.oc = OC_IDLE;
        held.rem = 16'd0;
      end
      held.last = 1'b1;
      pending_results.push_back(held);
    end
  endtask

  task automatic send_item(input stim_row_t row);
    result_t typed_res;
    start <= 1'b1;
    mode <= row.mode;
    task_id <= row.id;
    burst <= row.burst;
    level <= row.lvl;
    do @(posedge clk); while (busy);
    predict_schedule(row);
    if (row.typed) begin
      void'(pending_results.pop_back());
      typed_res.id = (row.e_oc == OC_IDLE) ? 8'd0 : row.id;
      typed_res.lvl = (row.e_oc == OC_IDLE) ? 2'd0 : row.lvl;
      typed_res.oc = row.e_oc;
      typed_res.rem = row.e_rem;
      typed_res.last = 1'b1;
      pending_results.push_back(typed_res);
    end
    if (run_left > 0) begin
      run_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      // now and then a long stretch of back-to-back commands
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slice(input logic [15:0] v);
    wait_idle();
    quantum_we <= 1'b1;
    quantum <= v;
    @(posedge clk);
    slice_now = v;
    quantum_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_burst();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      3: return slice_now;
      4: return slice_now + 16'd1;
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic stim_row_t random_row(input int pct);
    stim_row_t row;
    row.mode = ($urandom_range(0, 99) < pct) ? MODE_ADMIT : MODE_ROUND;
    row.id = 8'($urandom_range(0, 255));
    row.burst = pick_burst();
    row.lvl = 2'($urandom_range(0, 3));
    row.typed = 1'b0;
    row.e_oc = OC_FINISHED;
    row.e_rem = 16'd0;
    return row;
  endfunction

  // result checking: the receiver cannot stall, every strobe is a transaction
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result id %0d level %0d outcome %0d",
                                served_id, served_level, outcome));
      end else begin
        next_result = pending_results.pop_front();
        if (served_id !== next_result.id)
          flag_mismatch($sformatf("served_id %0d, expected %0d", served_id, next_result.id));
        if (served_level !== next_result.lvl)
          flag_mismatch($sformatf("served_level %0d, expected %0d",
                                  served_level, next_result.lvl));
        if (outcome !== next_result.oc)
          flag_mismatch($sformatf("outcome %0d, expected %s", outcome, next_result.oc.name()));
        if (remaining !== next_result.rem)
          flag_mismatch($sformatf("remaining %0d, expected %0d", remaining, next_result.rem));
        if (last !== next_result.last)
          flag_mismatch($sformatf("last %0b, expected %0b", last, next_result.last));
      end
    end
  end

  // only resets, accepted commands and expected results count as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || (strobe && pending_results.size() != 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      lv_head[lv] = 0;
      lv_tail[lv] = 0;
      lv_count[lv] = 0;
    end
    directed_rows = '{
      '{MODE_ROUND, 8'd0,   16'd0,     2'd0, 1'b1, OC_IDLE,     16'd0},
      '{MODE_ADMIT, 8'hFF,  16'hFFFF,  2'd3, 1'b1, OC_ADMITTED, 16'hFFFF},
      '{MODE_ADMIT, 8'h00,  16'h0000,  2'd0, 1'b1, OC_ADMITTED, 16'h0000},
      '{MODE_ADMIT, 8'hA5,  16'd4,     2'd2, 1'b1, OC_ADMITTED, 16'd4},
      '{MODE_ADMIT, 8'h5A,  16'd5,     2'd1, 1'b1, OC_ADMITTED, 16'd5},
      // demotions chase the task down through lower levels in one round
      '{MODE_ROUND, 8'h33,  16'hAAAA,  2'd1, 1'b0, OC_FINISHED, 16'd0},
      '{MODE_ROUND, 8'hCC,  16'h5555,  2'd2, 1'b0, OC_FINISHED, 16'd0},
      // lowest level cannot demote, task is dropped
      '{MODE_ROUND, 8'h0F,  16'h00F0,  2'd3, 1'b0, OC_FINISHED, 16'd0},
      '{MODE_ROUND, 8'hF0,  16'h0F0F,  2'd0, 1'b1, OC_IDLE,     16'd0}
    };
    slice_plan[0] = 16'hFFFF;
    slice_plan[1] = 16'd1;
    slice_plan[2] = 16'd0;
    slice_plan[3] = 16'($urandom_range(1, 65535));
    slice_plan[4] = 16'd16;
    slice_plan[5] = 16'($urandom_range(2, 40));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset slice value is exercised by the directed rows
    foreach (directed_rows[i])
      send_item(directed_rows[i]);

    for (int p = 0; p < 6; p++) begin
      write_slice(slice_plan[p]);
      repeat (PHASE_ITEMS)
        send_item(random_row(admit_pct[p]));
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> multilevel_feedback_round_scheduler.f
rtl/mfrs_pkg.sv
rtl/mfrs_front.sv
rtl/mfrs_back.sv
rtl/multilevel_feedback_round_scheduler.sv
rtl/mfrs_checker.sv
test/tb_top.sv
